// File: rtl/mtfr_pkg.sv
package mtfr_pkg;

    // Input word actions
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    // Result status codes, in order of test priority
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_BAD_START  = 3'd2,
        ST_BAD_TYPE   = 3'd3,
        ST_LEN_MISMAT = 3'd4,
        ST_CRC_ERR    = 3'd5
    } t_status;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;

    localparam logic [7:0]  EXPECTED_TYPE_RST = 8'd4;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    // Frame layout
    localparam int         MAX_FRAME_BYTES_DEF = 128;
    localparam int         CAPTURE_DEPTH       = 56;
    localparam logic [7:0] SHORT_FORM_MARK     = 8'h02;
    // start + length + crc(2) + end
    localparam int         FRAME_OVERHEAD      = 5;

    // Field offsets inside the frame
    localparam int OFS_TEMP_FET     = 3;
    localparam int OFS_TEMP_WINDING = 5;
    localparam int OFS_PHASE_CUR    = 7;
    localparam int OFS_SUPPLY_CUR   = 11;
    localparam int OFS_DUTY         = 23;
    localparam int OFS_SPEED        = 25;
    localparam int OFS_SUPPLY_VOLT  = 29;
    localparam int OFS_CHARGE       = 31;
    localparam int OFS_TACH         = 47;
    localparam int OFS_TACH_ABS     = 51;
    localparam int OFS_FAULT        = 55;

    typedef struct packed {
        t_action    action;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [7:0]         fault_code;
        logic signed [15:0] temp_fet;
        logic signed [15:0] temp_winding;
        logic signed [31:0] phase_current;
        logic signed [31:0] supply_current;
        logic [15:0]        duty;
        logic signed [31:0] speed_rpm;
        logic [15:0]        supply_voltage;
        logic [31:0]        charge_drawn;
        logic signed [31:0] tach_count;
        logic signed [31:0] tach_abs_count;
    } t_result;

    // CRC-16/XMODEM update by one byte (poly 0x1021, MSB first)
    function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/motor_telemetry_frame_receiver_unit.sv
// Motor telemetry frame receiver. Feed one word per received serial byte
// (action 1), one per millisecond tick (action 2), and a start word (action 0)
// before each reply. The block counts bytes, runs the payload through
// CRC-16/XMODEM and captures the telemetry bytes; when the frame completes,
// hits the maximum length or times out it delivers one result word with a
// status and the big-endian fields as raw scaled integers (all fields zero
// unless the status is ok). Input words are taken one per clock; a word
// passes an input register, then the frame parser writes any result for
// that word into the output register, which it loads only when it has
// room, that is when it is empty or its result leaves. The input stalls only
// while a finished result waits in the output register and the result side
// is stalled. Write the configuration registers only while no frame traffic
// is in flight.
module motor_telemetry_frame_receiver_unit #(
    parameter int P_MAX_FRAME_BYTES = mtfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_action,
    input  logic [7:0]                        i_rx_byte,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_status,
    output logic [7:0]                        o_fault_code,
    output logic signed [15:0]                o_temp_fet,
    output logic signed [15:0]                o_temp_winding,
    output logic signed [31:0]                o_phase_current,
    output logic signed [31:0]                o_supply_current,
    output logic [15:0]                       o_duty,
    output logic signed [31:0]                o_speed_rpm,
    output logic [15:0]                       o_supply_voltage,
    output logic [31:0]                       o_charge_drawn,
    output logic signed [31:0]                o_tach_count,
    output logic signed [31:0]                o_tach_abs_count,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [mtfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [7:0]        r_exp_type;
    logic [15:0]       r_timeout;
    logic              w_in_valid;
    mtfr_pkg::t_item   w_item;
    logic              w_out_ready;
    logic              w_advance;
    logic              w_close;
    mtfr_pkg::t_result w_result;
    mtfr_pkg::t_result w_out_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_type <= mtfr_pkg::EXPECTED_TYPE_RST;
            r_timeout  <= mtfr_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtfr_pkg::REG_EXPECTED_TYPE: r_exp_type <= i_cfg_data[7:0];
                mtfr_pkg::REG_TIMEOUT_TICKS: r_timeout  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // parser advances when output has room
    assign w_advance = w_in_valid && w_out_ready;

    mtfr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_action  (i_action),
        .i_rx_byte (i_rx_byte),
        .i_advance (w_advance),
        .o_stall   (o_in_stall),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    mtfr_parser #(
        .P_MAX_FRAME_BYTES (P_MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_advance),
        .i_item          (w_item),
        .i_expected_type (r_exp_type),
        .i_timeout_ticks (r_timeout),
        .o_close         (w_close),
        .o_result        (w_result)
    );

    mtfr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_close),
        .i_result (w_result),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_status         = w_out_result.status;
    assign o_fault_code     = w_out_result.fault_code;
    assign o_temp_fet       = w_out_result.temp_fet;
    assign o_temp_winding   = w_out_result.temp_winding;
    assign o_phase_current  = w_out_result.phase_current;
    assign o_supply_current = w_out_result.supply_current;
    assign o_duty           = w_out_result.duty;
    assign o_speed_rpm      = w_out_result.speed_rpm;
    assign o_supply_voltage = w_out_result.supply_voltage;
    assign o_charge_drawn   = w_out_result.charge_drawn;
    assign o_tach_count     = w_out_result.tach_count;
    assign o_tach_abs_count = w_out_result.tach_abs_count;

endmodule

// File: rtl/mtfr_in_stage.sv
module mtfr_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_advance,
    output logic                o_stall,
    output logic                o_valid,
    output mtfr_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    mtfr_pkg::t_item r_item;
    logic            w_accept;

    // Hold a word until the parser takes it
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && !i_advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action  <= mtfr_pkg::t_action'(i_action);
            r_item.rx_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/mtfr_parser.sv
module mtfr_parser #(
    parameter int P_MAX_FRAME_BYTES = mtfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  mtfr_pkg::t_item   i_item,
    input  logic [7:0]        i_expected_type,
    input  logic [15:0]       i_timeout_ticks,
    output logic              o_close,
    output mtfr_pkg::t_result o_result
);

    localparam int CW = $clog2(P_MAX_FRAME_BYTES + 1);
    localparam int AW = $clog2(mtfr_pkg::CAPTURE_DEPTH);
    // wide enough for length + overhead without wrapping
    localparam int LW = 9;

    logic        r_open,     n_open;
    logic [CW-1:0] r_count,  n_count;
    logic [15:0] r_ticks,    n_ticks;
    logic [7:0]  r_start,    n_start;
    logic [7:0]  r_len,      n_len;
    logic [7:0]  r_type,     n_type;
    logic [15:0] r_crc,      n_crc;
    logic [15:0] r_crc_seen, n_crc_seen;
    logic [7:0]  r_fields [mtfr_pkg::CAPTURE_DEPTH];
    logic [7:0]  n_fields [mtfr_pkg::CAPTURE_DEPTH];

    logic          w_close;
    logic [LW-1:0] w_off;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_cnt_next;
    logic [LW-1:0] w_full_len;
    logic [7:0]    w_b;
    mtfr_pkg::t_status w_status;

    assign w_b        = i_item.rx_byte;
    assign w_off      = LW'(r_count);
    assign w_len      = LW'(r_len);
    assign w_cnt_next = LW'(n_count);
    assign w_full_len = LW'(n_len) + LW'(mtfr_pkg::FRAME_OVERHEAD);

    // Next frame state for the word in the input register
    always_comb begin
        n_open     = r_open;
        n_count    = r_count;
        n_ticks    = r_ticks;
        n_start    = r_start;
        n_len      = r_len;
        n_type     = r_type;
        n_crc      = r_crc;
        n_crc_seen = r_crc_seen;
        n_fields   = r_fields;
        w_close    = 1'b0;
        if (i_en) begin
            case (i_item.action)
                mtfr_pkg::ACT_START: begin
                    n_open     = 1'b1;
                    n_count    = '0;
                    n_ticks    = '0;
                    n_start    = '0;
                    n_len      = '0;
                    n_type     = '0;
                    n_crc      = '0;
                    n_crc_seen = '0;
                    n_fields   = '{default: '0};
                end
                mtfr_pkg::ACT_BYTE: begin
                    if (r_open) begin
                        if (w_off < LW'(mtfr_pkg::CAPTURE_DEPTH)) begin
                            n_fields[r_count[AW-1:0]] = w_b;
                        end
                        if (w_off == LW'(0)) begin
                            n_start = w_b;
                        end else if (w_off == LW'(1)) begin
                            n_len = w_b;
                        end else begin
                            if (w_off == LW'(2)) begin
                                n_type = w_b;
                            end
                            if (w_off < w_len + LW'(2)) begin
                                n_crc = mtfr_pkg::crc_xmodem_byte(r_crc, w_b);
                            end else if (w_off == w_len + LW'(2)) begin
                                n_crc_seen = {w_b, r_crc_seen[7:0]};
                            end else if (w_off == w_len + LW'(3)) begin
                                n_crc_seen = {r_crc_seen[15:8], w_b};
                            end
                        end
                        n_count = r_count + CW'(1);
                        // close at max length or at the end of a short-form frame
                        if (n_count >= CW'(P_MAX_FRAME_BYTES)) begin
                            w_close = 1'b1;
                        end else if (w_cnt_next >= LW'(2) &&
                                     n_start == mtfr_pkg::SHORT_FORM_MARK &&
                                     w_cnt_next >= w_full_len) begin
                            w_close = 1'b1;
                        end
                    end
                end
                mtfr_pkg::ACT_TICK: begin
                    if (r_open) begin
                        if (r_ticks != 16'hFFFF) begin
                            n_ticks = r_ticks + 16'd1;
                        end
                        if (n_ticks >= i_timeout_ticks) begin
                            w_close = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (w_close) begin
                n_open = 1'b0;
            end
        end
    end

    // Status: first failing test wins
    always_comb begin
        if (w_cnt_next < LW'(3)) begin
            w_status = mtfr_pkg::ST_TOO_SHORT;
        end else if (n_start != mtfr_pkg::SHORT_FORM_MARK) begin
            w_status = mtfr_pkg::ST_BAD_START;
        end else if (n_type != i_expected_type) begin
            w_status = mtfr_pkg::ST_BAD_TYPE;
        end else if (w_cnt_next != w_full_len) begin
            w_status = mtfr_pkg::ST_LEN_MISMAT;
        end else if (n_crc_seen != n_crc) begin
            w_status = mtfr_pkg::ST_CRC_ERR;
        end else begin
            w_status = mtfr_pkg::ST_OK;
        end
    end

    // Big-endian field decode; all zero unless the frame is good
    always_comb begin
        o_result        = '0;
        o_result.status = w_status;
        if (w_status == mtfr_pkg::ST_OK) begin
            o_result.fault_code     = n_fields[mtfr_pkg::OFS_FAULT];
            o_result.temp_fet       = {n_fields[mtfr_pkg::OFS_TEMP_FET],
                                       n_fields[mtfr_pkg::OFS_TEMP_FET+1]};
            o_result.temp_winding   = {n_fields[mtfr_pkg::OFS_TEMP_WINDING],
                                       n_fields[mtfr_pkg::OFS_TEMP_WINDING+1]};
            o_result.phase_current  = {n_fields[mtfr_pkg::OFS_PHASE_CUR],
                                       n_fields[mtfr_pkg::OFS_PHASE_CUR+1],
                                       n_fields[mtfr_pkg::OFS_PHASE_CUR+2],
                                       n_fields[mtfr_pkg::OFS_PHASE_CUR+3]};
            o_result.supply_current = {n_fields[mtfr_pkg::OFS_SUPPLY_CUR],
                                       n_fields[mtfr_pkg::OFS_SUPPLY_CUR+1],
                                       n_fields[mtfr_pkg::OFS_SUPPLY_CUR+2],
                                       n_fields[mtfr_pkg::OFS_SUPPLY_CUR+3]};
            o_result.duty           = {n_fields[mtfr_pkg::OFS_DUTY],
                                       n_fields[mtfr_pkg::OFS_DUTY+1]};
            o_result.speed_rpm      = {n_fields[mtfr_pkg::OFS_SPEED],
                                       n_fields[mtfr_pkg::OFS_SPEED+1],
                                       n_fields[mtfr_pkg::OFS_SPEED+2],
                                       n_fields[mtfr_pkg::OFS_SPEED+3]};
            o_result.supply_voltage = {n_fields[mtfr_pkg::OFS_SUPPLY_VOLT],
                                       n_fields[mtfr_pkg::OFS_SUPPLY_VOLT+1]};
            o_result.charge_drawn   = {n_fields[mtfr_pkg::OFS_CHARGE],
                                       n_fields[mtfr_pkg::OFS_CHARGE+1],
                                       n_fields[mtfr_pkg::OFS_CHARGE+2],
                                       n_fields[mtfr_pkg::OFS_CHARGE+3]};
            o_result.tach_count     = {n_fields[mtfr_pkg::OFS_TACH],
                                       n_fields[mtfr_pkg::OFS_TACH+1],
                                       n_fields[mtfr_pkg::OFS_TACH+2],
                                       n_fields[mtfr_pkg::OFS_TACH+3]};
            o_result.tach_abs_count = {n_fields[mtfr_pkg::OFS_TACH_ABS],
                                       n_fields[mtfr_pkg::OFS_TACH_ABS+1],
                                       n_fields[mtfr_pkg::OFS_TACH_ABS+2],
                                       n_fields[mtfr_pkg::OFS_TACH_ABS+3]};
        end
    end

    assign o_close = w_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_count    <= '0;
            r_ticks    <= '0;
            r_start    <= '0;
            r_len      <= '0;
            r_type     <= '0;
            r_crc      <= '0;
            r_crc_seen <= '0;
        end else begin
            r_open     <= n_open;
            r_count    <= n_count;
            r_ticks    <= n_ticks;
            r_start    <= n_start;
            r_len      <= n_len;
            r_type     <= n_type;
            r_crc      <= n_crc;
            r_crc_seen <= n_crc_seen;
        end
    end

    // capture bytes; every start clears them before use
    always_ff @(posedge i_clk) begin
        r_fields <= n_fields;
    end

endmodule

// File: rtl/mtfr_out_stage.sv
module mtfr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mtfr_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output mtfr_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    mtfr_pkg::t_result r_result;

    // Free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: dv/tb_motor_telemetry_frame_receiver_unit.sv
`timescale 1ns / 100ps

module tb_motor_telemetry_frame_receiver_unit;
    import mtfr_pkg::*;

    // Codes the package does not name
    localparam logic [1:0]           ACT_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int HOLD_CYCLES     = 400;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int WORDS_PER_PHASE = 650;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_TICK_BURST  = 120;
    localparam int LONGEST_PAYLOAD = MAX_FRAME_BYTES_DEF - FRAME_OVERHEAD;

    typedef enum {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_TYPE,
        FR_BAD_START,
        FR_BAD_LEN,
        FR_OVERSIZE,
        FR_TRUNC,
        FR_DROPPED
    } t_frame_kind;

    // Frame decoder mirror plus the queue of results it predicts
    class frame_result_scoreboard;
        logic [7:0]  exp_type;
        logic [15:0] tmo;
        bit          is_open;
        logic [7:0]  nbytes;
        logic [15:0] ticks;
        logic [7:0]  start_b;
        logic [7:0]  len_b;
        logic [7:0]  type_b;
        logic [15:0] crc_acc;
        logic [15:0] crc_rx;
        logic [7:0]  cap [CAPTURE_DEPTH];
        t_result     pending_results[$];
        int          mismatches;

        function new();
            exp_type   = EXPECTED_TYPE_RST;
            tmo        = TIMEOUT_TICKS_RST;
            is_open    = 1'b0;
            mismatches = 0;
            clear_frame();
        endfunction

        // Bitwise LFSR form of CRC-16/XMODEM, one input bit per step
        static function logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] c;
            bit          fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
            end
            return c;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
            if (idx == REG_EXPECTED_TYPE) begin
                exp_type = data[7:0];
            end else if (idx == REG_TIMEOUT_TICKS) begin
                tmo = data;
            end
        endfunction

        function void clear_frame();
            nbytes  = '0;
            ticks   = '0;
            start_b = '0;
            len_b   = '0;
            type_b  = '0;
            crc_acc = '0;
            crc_rx  = '0;
            foreach (cap[i]) cap[i] = '0;
        endfunction

        function logic [15:0] be16(input int o);
            return {cap[o], cap[o+1]};
        endfunction

        function logic [31:0] be32(input int o);
            return {cap[o], cap[o+1], cap[o+2], cap[o+3]};
        endfunction

        // Status by priority; fields only on a clean frame
        function void close_frame();
            t_result r;
            int      full_len;
            is_open  = 1'b0;
            full_len = int'(len_b) + FRAME_OVERHEAD;
            r        = '0;
            if (nbytes < 8'd3) begin
                r.status = ST_TOO_SHORT;
            end else if (start_b != SHORT_FORM_MARK) begin
                r.status = ST_BAD_START;
            end else if (type_b != exp_type) begin
                r.status = ST_BAD_TYPE;
            end else if (int'(nbytes) != full_len) begin
                r.status = ST_LEN_MISMAT;
            end else if (crc_rx != crc_acc) begin
                r.status = ST_CRC_ERR;
            end else begin
                r.status         = ST_OK;
                r.fault_code     = cap[OFS_FAULT];
                r.temp_fet       = be16(OFS_TEMP_FET);
                r.temp_winding   = be16(OFS_TEMP_WINDING);
                r.phase_current  = be32(OFS_PHASE_CUR);
                r.supply_current = be32(OFS_SUPPLY_CUR);
                r.duty           = be16(OFS_DUTY);
                r.speed_rpm      = be32(OFS_SPEED);
                r.supply_voltage = be16(OFS_SUPPLY_VOLT);
                r.charge_drawn   = be32(OFS_CHARGE);
                r.tach_count     = be32(OFS_TACH);
                r.tach_abs_count = be32(OFS_TACH_ABS);
            end
            pending_results.push_back(r);
        endfunction

        // Returns 1 when the word had an effect on the decoder
        function bit take_word(input logic [1:0] act, input logic [7:0] b);
            int off;
            int len;
            if (act == ACT_START) begin
                clear_frame();
                is_open = 1'b1;
                return 1'b1;
            end
            if (!is_open) return 1'b0;
            if (act == ACT_BYTE) begin
                off = int'(nbytes);
                len = int'(len_b);
                if (off < CAPTURE_DEPTH) cap[off] = b;
                if (off == 0) begin
                    start_b = b;
                end else if (off == 1) begin
                    len_b = b;
                end else begin
                    if (off == 2) type_b = b;
                    if (off < 2 + len) begin
                        crc_acc = crc_update(crc_acc, b);
                    end else if (off == 2 + len) begin
                        crc_rx[15:8] = b;
                    end else if (off == 3 + len) begin
                        crc_rx[7:0] = b;
                    end
                end
                nbytes = nbytes + 8'd1;
                if (int'(nbytes) >= MAX_FRAME_BYTES_DEF) begin
                    close_frame();
                end else if (nbytes >= 8'd2 && start_b == SHORT_FORM_MARK &&
                             int'(nbytes) >= int'(len_b) + FRAME_OVERHEAD) begin
                    close_frame();
                end
                return 1'b1;
            end
            if (act == ACT_TICK) begin
                if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
                if (ticks >= tmo) close_frame();
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit field_ok(input string name, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(input t_result got);
            t_result want;
            int      bad;
            if (pending_results.size() == 0) begin
                $error("result word with no expectation, status %0d", got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            bad  = 0;
            bad += !field_ok("status", want.status, got.status);
            bad += !field_ok("fault_code", want.fault_code, got.fault_code);
            bad += !field_ok("temp_fet", want.temp_fet, got.temp_fet);
            bad += !field_ok("temp_winding", want.temp_winding, got.temp_winding);
            bad += !field_ok("phase_current", want.phase_current, got.phase_current);
            bad += !field_ok("supply_current", want.supply_current, got.supply_current);
            bad += !field_ok("duty", want.duty, got.duty);
            bad += !field_ok("speed_rpm", want.speed_rpm, got.speed_rpm);
            bad += !field_ok("supply_voltage", want.supply_voltage, got.supply_voltage);
            bad += !field_ok("charge_drawn", want.charge_drawn, got.charge_drawn);
            bad += !field_ok("tach_count", want.tach_count, got.tach_count);
            bad += !field_ok("tach_abs_count", want.tach_abs_count, got.tach_abs_count);
            if (bad != 0) mismatches++;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    bit                    i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [1:0]            i_action     = '0;
    logic [7:0]            i_rx_byte    = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [2:0]            o_status;
    logic [7:0]            o_fault_code;
    logic signed [15:0]    o_temp_fet;
    logic signed [15:0]    o_temp_winding;
    logic signed [31:0]    o_phase_current;
    logic signed [31:0]    o_supply_current;
    logic [15:0]           o_duty;
    logic signed [31:0]    o_speed_rpm;
    logic [15:0]           o_supply_voltage;
    logic [31:0]           o_charge_drawn;
    logic signed [31:0]    o_tach_count;
    logic signed [31:0]    o_tach_abs_count;

    frame_result_scoreboard sb;
    int          used_words   = 0;
    logic [7:0]  cur_type     = EXPECTED_TYPE_RST;
    logic [15:0] cur_timeout  = TIMEOUT_TICKS_RST;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          hold_req     = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    int          cycles       = 0;

    motor_telemetry_frame_receiver_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_fault_code    (o_fault_code),
        .o_temp_fet      (o_temp_fet),
        .o_temp_winding  (o_temp_winding),
        .o_phase_current (o_phase_current),
        .o_supply_current(o_supply_current),
        .o_duty          (o_duty),
        .o_speed_rpm     (o_speed_rpm),
        .o_supply_voltage(o_supply_voltage),
        .o_charge_drawn  (o_charge_drawn),
        .o_tach_count    (o_tach_count),
        .o_tach_abs_count(o_tach_abs_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("motor_telemetry_frame_receiver_unit regression: fail");
            $finish;
        end
    end

    // Result side back-pressure; a requested hold-off overrides the random stall
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Result word capture
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status         = t_status'(o_status);
            got.fault_code     = o_fault_code;
            got.temp_fet       = o_temp_fet;
            got.temp_winding   = o_temp_winding;
            got.phase_current  = o_phase_current;
            got.supply_current = o_supply_current;
            got.duty           = o_duty;
            got.speed_rpm      = o_speed_rpm;
            got.supply_voltage = o_supply_voltage;
            got.charge_drawn   = o_charge_drawn;
            got.tach_count     = o_tach_count;
            got.tach_abs_count = o_tach_abs_count;
            sb.check_result(got);
        end
    end

    // One input word; called and returns at a falling edge
    task automatic send_word(input logic [1:0] act, input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (sb.take_word(act, b)) used_words++;
        @(negedge i_clk);
    endtask

    // Quiet input, all results in, pipeline drained
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] type_word, input logic [15:0] tmo_word,
                                input bit with_spare);
        logic [15:0] junk;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_EXPECTED_TYPE;
        i_cfg_data  <= type_word;
        sb.write_reg(REG_EXPECTED_TYPE, type_word);
        @(negedge i_clk);
        i_cfg_index <= REG_TIMEOUT_TICKS;
        i_cfg_data  <= tmo_word;
        sb.write_reg(REG_TIMEOUT_TICKS, tmo_word);
        @(negedge i_clk);
        if (with_spare) begin
            // unmapped indexes must not disturb anything
            junk = 16'($urandom);
            i_cfg_index <= REG_SPARE_A;
            i_cfg_data  <= junk;
            sb.write_reg(REG_SPARE_A, junk);
            @(negedge i_clk);
            junk = 16'($urandom);
            i_cfg_index <= REG_SPARE_B;
            i_cfg_data  <= junk;
            sb.write_reg(REG_SPARE_B, junk);
            @(negedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        cur_type    = type_word[7:0];
        cur_timeout = tmo_word;
    endtask

    // Byte with an occasional tick or spare action slipped in ahead of it
    task automatic send_frame_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < 2) send_word(ACT_TICK, 8'($urandom));
        if ($urandom_range(0, 99) == 0) send_word(ACT_SPARE, 8'($urandom));
        send_word(ACT_BYTE, b);
    endtask

    task automatic send_frame(input int n, input t_frame_kind kind);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        logic [7:0]  b;
        int          keep;
        int          nticks;
        crc = '0;
        fr.push_back(SHORT_FORM_MARK);
        fr.push_back(8'(n));
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                b = (kind == FR_BAD_TYPE) ? cur_type ^ 8'($urandom_range(1, 255)) : cur_type;
            end else begin
                b = 8'($urandom);
            end
            fr.push_back(b);
            crc = frame_result_scoreboard::crc_update(crc, b);
        end
        fr.push_back(crc[15:8]);
        fr.push_back(crc[7:0]);
        fr.push_back(8'($urandom));
        keep = fr.size();
        case (kind)
            FR_BAD_CRC: begin
                fr[2 + n + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            FR_BAD_START: begin
                do b = 8'($urandom); while (b == SHORT_FORM_MARK);
                fr[0] = b;
            end
            FR_BAD_LEN: begin
                fr[1] = fr[1] + 8'($urandom_range(1, 255));
            end
            FR_OVERSIZE: begin
                // length byte too large to fit; frame runs to the size cap
                fr[1] = 8'($urandom_range(LONGEST_PAYLOAD + 1, 255));
            end
            FR_TRUNC, FR_DROPPED: begin
                keep = $urandom_range(0, fr.size() - 1);
            end
            default: begin
            end
        endcase
        send_word(ACT_START, 8'($urandom));
        for (int i = 0; i < keep; i++) send_frame_byte(fr[i]);
        // frames that will not close on their own get ticks toward the timeout, at most MAX_TICK_BURST
        if (kind == FR_BAD_START || kind == FR_BAD_LEN || kind == FR_TRUNC) begin
            nticks = (int'(cur_timeout) < MAX_TICK_BURST) ? int'(cur_timeout) : MAX_TICK_BURST;
            repeat (nticks) send_word(ACT_TICK, 8'($urandom));
        end
    endtask

    task automatic random_frame();
        int r;
        int s;
        int n;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        // mostly lengths that reach the telemetry fields
        if (s < 50) begin
            n = $urandom_range(51, 70);
        end else if (s < 75) begin
            n = $urandom_range(0, 12);
        end else if (s < 90) begin
            n = $urandom_range(13, 50);
        end else begin
            n = $urandom_range(71, LONGEST_PAYLOAD);
        end
        if (r < 60) begin
            send_frame(n, FR_GOOD);
        end else if (r < 68) begin
            send_frame(n, FR_BAD_CRC);
        end else if (r < 74) begin
            send_frame(n, FR_BAD_TYPE);
        end else if (r < 78) begin
            send_frame(n, FR_BAD_START);
        end else if (r < 83) begin
            send_frame(n, FR_BAD_LEN);
        end else if (r < 86) begin
            send_frame(LONGEST_PAYLOAD, FR_OVERSIZE);
        end else if (r < 91) begin
            send_frame(n, FR_TRUNC);
        end else if (r < 95) begin
            send_frame(n, FR_DROPPED);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_word(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] crc;
        int          target;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: words while closed are ignored, spare action too
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_SPARE, 8'hFF);
        // shortest clean frame; CRC and end byte land in the field offsets
        crc = frame_result_scoreboard::crc_update(16'h0000, EXPECTED_TYPE_RST);
        send_word(ACT_START, 8'h00);
        send_word(ACT_BYTE, SHORT_FORM_MARK);
        send_word(ACT_BYTE, 8'h01);
        send_word(ACT_BYTE, EXPECTED_TYPE_RST);
        send_word(ACT_BYTE, crc[15:8]);
        send_word(ACT_BYTE, crc[7:0]);
        send_word(ACT_BYTE, 8'hA5);
        // restart while open drops the frame silently
        send_word(ACT_START, 8'h00);
        send_word(ACT_BYTE, SHORT_FORM_MARK);
        send_word(ACT_START, 8'h00);
        wait_idle();
        program_regs(16'h5AFF, 16'd1, 1'b0);
        // oversized length byte, closed by a one-tick timeout
        send_word(ACT_BYTE, SHORT_FORM_MARK);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_START, 8'h00);
        send_word(ACT_TICK, 8'h00);
        wait_idle();
        program_regs(16'h0004, 16'd0, 1'b1);
        // zero timeout: first tick closes
        send_word(ACT_START, 8'h00);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_START, 8'h00);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'h01);
        send_word(ACT_BYTE, 8'h02);
        send_word(ACT_TICK, 8'h00);

        // Random phases with different idling and register settings
        target = used_words;
        for (int p = 0; p < 3; p++) begin
            wait_idle();
            case (p)
                0: begin
                    tx_idle_pct  = 28;
                    rx_stall_pct <= 47;
                    program_regs(16'($urandom), TIMEOUT_TICKS_RST, 1'b0);
                end
                1: begin
                    tx_idle_pct  = 47;
                    rx_stall_pct <= 28;
                    program_regs({8'($urandom), 8'h00}, 16'hFFFF, 1'b0);
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 0;
                    program_regs({8'($urandom), 8'hFF}, 16'($urandom_range(30, 60)), 1'b1);
                    // long result hold-off while short frames keep coming
                    hold_req <= hold_req + 1;
                    repeat (12) send_frame($urandom_range(0, 3), FR_GOOD);
                end
            endcase
            target += WORDS_PER_PHASE;
            while (used_words < target) random_frame();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("motor_telemetry_frame_receiver_unit regression: pass");
        end else begin
            $display("motor_telemetry_frame_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule
